// ===== hw/rtl/tss_pkg.sv =====
package tss_pkg;

    localparam int MAX_TERMS  = 16;
    localparam int FRAC_BITS  = 28;
    localparam int RECIP_BITS = 62;

    localparam int ANGLE_W   = 32;
    localparam int TERMS_W   = 5;
    localparam int OUT_W     = 48;
    localparam int WORD_W    = 64;
    localparam int HALF_W    = WORD_W / 2;
    localparam int ACC_W     = 2 * WORD_W;
    localparam int COUNT_W   = $clog2(MAX_TERMS + 1);
    localparam int TBL_DEPTH = 32;
    localparam int TBL_IDX_W = $clog2(TBL_DEPTH);
    localparam int PP_W      = 2;

    localparam logic [PP_W-1:0]   PP_LAST    = 2'd3;
    localparam logic [WORD_W-1:0] SAT_VALUE  = {1'b0, {(WORD_W - 1){1'b1}}};
    localparam logic [ACC_W-1:0]  HALF_FRAC  = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic [ACC_W-1:0]  HALF_RECIP = ACC_W'(1) << (RECIP_BITS - 1);
    localparam logic [WORD_W-1:0] RECIP_ONE  = WORD_W'(1) << RECIP_BITS;

    // Entry k holds 1/((2i)(2i+1)) for i = k + 1, unsigned Q0.62, rounded to nearest.
    localparam logic [WORD_W-1:0] RECIP_TABLE [TBL_DEPTH] = '{
        (RECIP_ONE + 64'd3)    / 64'd6,
        (RECIP_ONE + 64'd10)   / 64'd20,
        (RECIP_ONE + 64'd21)   / 64'd42,
        (RECIP_ONE + 64'd36)   / 64'd72,
        (RECIP_ONE + 64'd55)   / 64'd110,
        (RECIP_ONE + 64'd78)   / 64'd156,
        (RECIP_ONE + 64'd105)  / 64'd210,
        (RECIP_ONE + 64'd136)  / 64'd272,
        (RECIP_ONE + 64'd171)  / 64'd342,
        (RECIP_ONE + 64'd210)  / 64'd420,
        (RECIP_ONE + 64'd253)  / 64'd506,
        (RECIP_ONE + 64'd300)  / 64'd600,
        (RECIP_ONE + 64'd351)  / 64'd702,
        (RECIP_ONE + 64'd406)  / 64'd812,
        (RECIP_ONE + 64'd465)  / 64'd930,
        (RECIP_ONE + 64'd528)  / 64'd1056,
        (RECIP_ONE + 64'd595)  / 64'd1190,
        (RECIP_ONE + 64'd666)  / 64'd1332,
        (RECIP_ONE + 64'd741)  / 64'd1482,
        (RECIP_ONE + 64'd820)  / 64'd1640,
        (RECIP_ONE + 64'd903)  / 64'd1806,
        (RECIP_ONE + 64'd990)  / 64'd1980,
        (RECIP_ONE + 64'd1081) / 64'd2162,
        (RECIP_ONE + 64'd1176) / 64'd2352,
        (RECIP_ONE + 64'd1275) / 64'd2550,
        (RECIP_ONE + 64'd1378) / 64'd2756,
        (RECIP_ONE + 64'd1485) / 64'd2970,
        (RECIP_ONE + 64'd1596) / 64'd3192,
        (RECIP_ONE + 64'd1711) / 64'd3422,
        (RECIP_ONE + 64'd1830) / 64'd3660,
        (RECIP_ONE + 64'd1953) / 64'd3906,
        (RECIP_ONE + 64'd2080) / 64'd4160
    };

    typedef enum logic [1:0] {
        MOP_SQUARE,
        MOP_TX2,
        MOP_RECIP
    } mul_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_SQUARE_WB,
        S_MUL_X2,
        S_X2_WB,
        S_MUL_RECIP,
        S_RECIP_WB,
        S_DONE
    } tss_state_t;

    typedef struct packed {
        logic            load;
        logic            mul_en;
        mul_op_t         op;
        logic [PP_W-1:0] pp_idx;
        logic            wb_en;
        logic            out_write;
    } tss_cmd_t;

    typedef struct packed {
        logic has_terms;
        logic last_term;
    } tss_status_t;

endpackage

// ===== hw/rtl/taylor_sine_series.sv =====
// Channel  Direction  Handshake             Payload
// input    in         in_valid / in_stall   angle (32, signed Q3.28), terms (5)
// output   out        out_valid / out_stall sine_value (48, signed Q19.28)
//
// With n the term count clamped to sixteen, the result is built from one square and n terms.
// The next transaction is taken only once the result is written to the output register.
// All products share the single 32x32 multiplier: every product is built from four partial
// products and then written back, and each term needs two products.
// Reset clears the controller state and the output valid flag; data registers are not reset.
// A new transaction is accepted while a finished result waits in the output register.
module taylor_sine_series
    import tss_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [ANGLE_W-1:0] angle,
    input  logic        [TERMS_W-1:0] terms,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [OUT_W-1:0]   sine_value
);

    tss_cmd_t    cmd;
    tss_status_t status;

    tss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    tss_dp u_dp (
        .clk        (clk),
        .cmd        (cmd),
        .status     (status),
        .angle      (angle),
        .terms      (terms),
        .sine_value (sine_value)
    );

endmodule

// ===== hw/rtl/tss_ctrl.sv =====
module tss_ctrl
    import tss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    output logic        out_valid,
    input  logic        out_stall,
    input  tss_status_t status,
    output tss_cmd_t    cmd
);

    tss_state_t      state_reg;
    tss_state_t      state_next;
    logic [PP_W-1:0] pp_reg;
    logic [PP_W-1:0] pp_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pp_reg        <= pp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        pp_next        = pp_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SQUARE;
                end
            end
            S_SQUARE:
            begin
                cmd.mul_en = 1'b1;
                cmd.op     = MOP_SQUARE;
                cmd.pp_idx = pp_reg;
                pp_next    = pp_reg + 1'b1;
                if (pp_reg == PP_LAST)
                begin
                    state_next = S_SQUARE_WB;
                end
            end
            S_SQUARE_WB:
            begin
                cmd.wb_en  = 1'b1;
                cmd.op     = MOP_SQUARE;
                state_next = status.has_terms ? S_MUL_X2 : S_DONE;
            end
            S_MUL_X2:
            begin
                cmd.mul_en = 1'b1;
                cmd.op     = MOP_TX2;
                cmd.pp_idx = pp_reg;
                pp_next    = pp_reg + 1'b1;
                if (pp_reg == PP_LAST)
                begin
                    state_next = S_X2_WB;
                end
            end
            S_X2_WB:
            begin
                cmd.wb_en  = 1'b1;
                cmd.op     = MOP_TX2;
                state_next = S_MUL_RECIP;
            end
            S_MUL_RECIP:
            begin
                cmd.mul_en = 1'b1;
                cmd.op     = MOP_RECIP;
                cmd.pp_idx = pp_reg;
                pp_next    = pp_reg + 1'b1;
                if (pp_reg == PP_LAST)
                begin
                    state_next = S_RECIP_WB;
                end
            end
            S_RECIP_WB:
            begin
                cmd.wb_en  = 1'b1;
                cmd.op     = MOP_RECIP;
                state_next = status.last_term ? S_DONE : S_MUL_X2;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_write  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/tss_dp.sv =====
module tss_dp
    import tss_pkg::*;
(
    input  logic                      clk,
    input  tss_cmd_t                  cmd,
    output tss_status_t               status,
    input  logic signed [ANGLE_W-1:0] angle,
    input  logic        [TERMS_W-1:0] terms,
    output logic signed [OUT_W-1:0]   sine_value
);

    logic [ANGLE_W-1:0]   mag_reg;
    logic                 neg_reg;
    logic [OUT_W-1:0]     sum_reg;
    logic [WORD_W-1:0]    x2_reg;
    logic [WORD_W-1:0]    t_reg;
    logic [ACC_W-1:0]     acc_reg;
    logic [ACC_W-1:0]     acc_next;
    logic [COUNT_W-1:0]   n_reg;
    logic [COUNT_W-1:0]   n_next;
    logic [COUNT_W-1:0]   idx_reg;
    logic [COUNT_W-1:0]   idx_m1;
    logic [OUT_W-1:0]     sine_value_reg;

    logic [ANGLE_W-1:0]   angle_mag;
    logic [WORD_W-1:0]    op_a;
    logic [WORD_W-1:0]    op_b;
    logic                 recip_shift;
    logic [HALF_W-1:0]    a_half;
    logic [HALF_W-1:0]    b_half;
    logic [WORD_W-1:0]    pp;
    logic [ACC_W-1:0]     pp_wide;
    logic [ACC_W-1:0]     acc_base;
    logic [ACC_W-1:0]     shifted;
    logic [WORD_W-1:0]    res;
    logic [OUT_W-1:0]     sum_next;
    logic [TBL_IDX_W-1:0] tbl_idx;

    assign angle_mag = angle[ANGLE_W-1] ? (~angle + 1'b1) : angle;
    assign idx_m1    = idx_reg - 1'b1;
    assign tbl_idx   = TBL_IDX_W'(idx_m1);

    always_comb
    begin
        if (int'(terms) > MAX_TERMS)
        begin
            n_next = COUNT_W'(MAX_TERMS);
        end
        else
        begin
            n_next = COUNT_W'(terms);
        end
    end

    always_comb
    begin
        op_a        = '0;
        op_b        = '0;
        recip_shift = 1'b0;
        unique case (cmd.op)
            MOP_SQUARE:
            begin
                op_a = WORD_W'(mag_reg);
                op_b = WORD_W'(mag_reg);
            end
            MOP_TX2:
            begin
                op_a = t_reg;
                op_b = x2_reg;
            end
            MOP_RECIP:
            begin
                op_a        = t_reg;
                op_b        = RECIP_TABLE[tbl_idx];
                recip_shift = 1'b1;
            end
            default:
            begin
                op_a = '0;
            end
        endcase
    end

    // One 32x32 partial product per cycle; the accumulator starts from the rounding half.
    assign a_half = cmd.pp_idx[0] ? op_a[WORD_W-1:HALF_W] : op_a[HALF_W-1:0];
    assign b_half = cmd.pp_idx[1] ? op_b[WORD_W-1:HALF_W] : op_b[HALF_W-1:0];
    assign pp     = WORD_W'(a_half) * WORD_W'(b_half);

    always_comb
    begin
        case (cmd.pp_idx) inside
            2'd0:
            begin
                pp_wide = ACC_W'(pp);
            end
            2'd1, 2'd2:
            begin
                pp_wide = ACC_W'(pp) << HALF_W;
            end
            default:
            begin
                pp_wide = ACC_W'(pp) << WORD_W;
            end
        endcase
    end

    assign acc_base = (cmd.pp_idx == '0) ? (recip_shift ? HALF_RECIP : HALF_FRAC) : acc_reg;
    assign acc_next = acc_base + pp_wide;

    assign shifted = recip_shift ? (acc_reg >> RECIP_BITS) : (acc_reg >> FRAC_BITS);
    assign res     = (|shifted[ACC_W-1:WORD_W-1]) ? SAT_VALUE : shifted[WORD_W-1:0];

    // The new term takes the opposite sign of the previous one.
    assign sum_next = neg_reg ? (sum_reg + res[OUT_W-1:0]) : (sum_reg - res[OUT_W-1:0]);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mag_reg <= angle_mag;
            neg_reg <= angle[ANGLE_W-1];
            sum_reg <= OUT_W'(angle);
            t_reg   <= WORD_W'(angle_mag);
            n_reg   <= n_next;
            idx_reg <= COUNT_W'(1);
        end
        if (cmd.mul_en)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.wb_en)
        begin
            unique case (cmd.op)
                MOP_SQUARE:
                begin
                    x2_reg <= res;
                end
                MOP_TX2:
                begin
                    t_reg <= res;
                end
                MOP_RECIP:
                begin
                    t_reg   <= res;
                    neg_reg <= ~neg_reg;
                    sum_reg <= sum_next;
                    idx_reg <= idx_reg + 1'b1;
                end
                default:
                begin
                    t_reg <= t_reg;
                end
            endcase
        end
        if (cmd.out_write)
        begin
            sine_value_reg <= sum_reg;
        end
    end

    assign status.has_terms = (n_reg != '0);
    assign status.last_term = (idx_reg == n_reg);
    assign sine_value       = sine_value_reg;

endmodule

// ===== hw/rtl/tss_checker.sv =====
module tss_checker
    import tss_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic signed [ANGLE_W-1:0] angle,
    input logic        [TERMS_W-1:0] terms,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic signed [OUT_W-1:0]   sine_value
);

    // A stalled result stays in place.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sine_value))
    else $error("stalled result changed");

    // The block works on one transaction at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
    else $error("transaction accepted while busy");

    // A result appears only at the end of a busy period.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
    else $error("result without a transaction in flight");

    // With no correction terms the result is the angle, sign-extended.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (terms == '0) && !out_valid |->
        ##7 out_valid &&
        (sine_value == {{(OUT_W - ANGLE_W){$past(angle[ANGLE_W-1], 7)}}, $past(angle, 7)}))
    else $error("zero-term result differs from angle");

endmodule

bind taylor_sine_series tss_checker u_checker (.*);

// ===== sim/tb_taylor_sine_series.sv =====
module tb_taylor_sine_series
    import tss_pkg::*;
();

    localparam int DRAIN_CYCLES   = 200;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_PER_PHASE = 480;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic [TERMS_W-1:0] terms;
        logic               known;
        logic [OUT_W-1:0]   sine;
    } sine_case_t;

    // Rows with known cleared are checked against the series predictor.
    localparam sine_case_t DIRECTED_CASES [18] = '{
        '{32'h0000_0000, 5'd0,  1'b1, 48'h0000_0000_0000},
        '{32'h0000_0000, 5'd16, 1'b1, 48'h0000_0000_0000},
        '{32'h0000_0001, 5'd0,  1'b1, 48'h0000_0000_0001},
        '{32'hFFFF_FFFF, 5'd0,  1'b1, 48'hFFFF_FFFF_FFFF},
        '{32'h7FFF_FFFF, 5'd0,  1'b1, 48'h0000_7FFF_FFFF},
        '{32'h8000_0000, 5'd0,  1'b1, 48'hFFFF_8000_0000},
        '{32'h7FFF_FFFF, 5'd16, 1'b0, 48'h0},
        '{32'h8000_0000, 5'd16, 1'b0, 48'h0},
        '{32'h7FFF_FFFF, 5'd31, 1'b0, 48'h0},
        '{32'h8000_0000, 5'd17, 1'b0, 48'h0},
        '{32'h0000_0001, 5'd16, 1'b0, 48'h0},
        '{32'hFFFF_FFFF, 5'd31, 1'b0, 48'h0},
        '{32'h1921_FB54, 5'd1,  1'b0, 48'h0},
        '{32'h1921_FB54, 5'd8,  1'b0, 48'h0},
        '{32'hCDBC_0957, 5'd16, 1'b0, 48'h0},
        '{32'h5555_5555, 5'd31, 1'b0, 48'h0},
        '{32'hAAAA_AAAA, 5'd5,  1'b0, 48'h0},
        '{32'h1000_0000, 5'd3,  1'b0, 48'h0}
    };

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic signed [ANGLE_W-1:0] angle = '0;
    logic        [TERMS_W-1:0] terms = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic signed [OUT_W-1:0]   sine_value;

    logic [OUT_W-1:0] sine_expect_q [$];
    logic [OUT_W-1:0] expected_sine;
    int               error_count = 0;
    int               quiet_cycles = 0;
    int               send_idle_pct = 0;
    int               stall_pct = 0;

    taylor_sine_series dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .angle      (angle),
        .terms      (terms),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sine_value (sine_value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [WORD_W-1:0] scaled_product(input logic [WORD_W-1:0] a,
                                                         input logic [WORD_W-1:0] b,
                                                         input int shift);
        logic [ACC_W-1:0] prod;
        prod = {{WORD_W{1'b0}}, a} * {{WORD_W{1'b0}}, b};
        prod = (prod + (ACC_W'(1) << (shift - 1))) >> shift;
        if (prod > ACC_W'(SAT_VALUE))
            return SAT_VALUE;
        return prod[WORD_W-1:0];
    endfunction

    function automatic logic [WORD_W-1:0] term_divisor_inverse(input int k);
        logic [WORD_W-1:0] d;
        d = WORD_W'(2 * k) * WORD_W'(2 * k + 1);
        return ((WORD_W'(1) << RECIP_BITS) + d / 2) / d;
    endfunction

    function automatic logic [OUT_W-1:0] series_sine(input logic [ANGLE_W-1:0] x,
                                                     input logic [TERMS_W-1:0] count);
        logic              negative;
        logic [WORD_W-1:0] mag;
        logic [WORD_W-1:0] total;
        logic [WORD_W-1:0] x_sq;
        logic [WORD_W-1:0] term;
        int                n;
        negative = x[ANGLE_W-1];
        mag = negative ? (WORD_W'(64'h1_0000_0000) - WORD_W'(x)) : WORD_W'(x);
        total = negative ? -mag : mag;
        x_sq = scaled_product(mag, mag, FRAC_BITS);
        term = mag;
        n = (count > MAX_TERMS) ? MAX_TERMS : int'(count);
        for (int i = 1; i <= n; i++)
        begin
            term = scaled_product(term, x_sq, FRAC_BITS);
            term = scaled_product(term, term_divisor_inverse(i), RECIP_BITS);
            negative = !negative;
            total = negative ? (total - term) : (total + term);
        end
        return total[OUT_W-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR: %s", msg);
        error_count++;
    endtask

    task automatic send_angle(input logic [ANGLE_W-1:0] a, input logic [TERMS_W-1:0] n,
                              input logic [OUT_W-1:0] want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        angle <= a;
        terms <= n;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sine_expect_q.push_back(want);
    endtask

    task automatic run_random(input int count);
        logic [ANGLE_W-1:0] a;
        logic [TERMS_W-1:0] n;
        for (int k = 0; k < count; k++)
        begin
            case ($urandom_range(9))
                6, 7: a = $urandom_range(32'h4000_0000) - 32'h2000_0000;
                8: a = $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(4095)
                                         : 32'h8000_0000 + $urandom_range(4095);
                9: a = $urandom_range(1) ? $urandom_range(255) : -$urandom_range(255);
                default: a = $urandom;
            endcase
            n = ($urandom_range(99) < 85) ? TERMS_W'($urandom_range(MAX_TERMS))
                                          : TERMS_W'($urandom_range(31, 17));
            send_angle(a, n, series_sine(a, n));
        end
    endtask

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (out_valid && !out_stall)
            begin
                if (sine_expect_q.size() == 0)
                    report_mismatch($sformatf("sine_value %h with no transaction outstanding",
                                              sine_value));
                else
                begin
                    expected_sine = sine_expect_q.pop_front();
                    if (sine_value !== expected_sine)
                        report_mismatch($sformatf("sine_value %h, expected %h",
                                                  sine_value, expected_sine));
                end
            end
        end
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("taylor_sine_series regression: fail");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 20;
        stall_pct = 82;
        foreach (DIRECTED_CASES[k])
            send_angle(DIRECTED_CASES[k].angle, DIRECTED_CASES[k].terms,
                       DIRECTED_CASES[k].known ? DIRECTED_CASES[k].sine
                                               : series_sine(DIRECTED_CASES[k].angle,
                                                             DIRECTED_CASES[k].terms));
        run_random(RANDOM_PER_PHASE);

        send_idle_pct = 82;
        stall_pct = 20;
        run_random(RANDOM_PER_PHASE);

        send_idle_pct = 0;
        stall_pct = 0;
        run_random(RANDOM_PER_PHASE);
        in_valid <= 1'b0;

        while (sine_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("taylor_sine_series regression: pass");
        else
            $display("taylor_sine_series regression: fail");
        $finish;
    end

endmodule
